@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the condition holds at every clock edge outside reset.
`define VCTS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Checks that the consequent holds whenever the antecedent holds.
`define VCTS_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/vcts_pkg.sv @@
// Shared types, constants and helpers of the cluster transfer splitter.
package vcts_pkg;

  localparam int OFFSET_W     = 31;
  localparam int LEN_W        = 18;
  localparam int INDEX_W      = 19;
  localparam int OFS_W        = 18;
  localparam int SIZE_W       = 19;
  localparam int MULT_W       = 7;
  localparam int COUNT_W      = 16;
  localparam int GRAN_SHIFT   = 12;
  localparam int GRAN_W       = OFFSET_W - GRAN_SHIFT;
  localparam int DREM_W       = 6;
  localparam int PROD_W       = MULT_W + COUNT_W;
  localparam int BASE_W       = COUNT_W + 1;
  localparam int SEGCNT_W     = 6;
  localparam int DIVCNT_W     = 5;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [LEN_W-1:0]    MAX_LENGTH = LEN_W'(131072);
  localparam logic [SEGCNT_W-1:0] SEG_LAST   = SEGCNT_W'(32);
  localparam logic [DIVCNT_W-1:0] DIV_LAST   = DIVCNT_W'(GRAN_W - 1);
  localparam logic [MULT_W-1:0]   MULT_MAX   = MULT_W'(64);

  localparam logic [CFG_IDX_W-1:0] REG_RANGE0_MULT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE0_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE1_MULT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE1_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE2_MULT  = 3'd4;

  typedef struct packed {
    logic [MULT_W-1:0]  m0;
    logic [COUNT_W-1:0] c0;
    logic [MULT_W-1:0]  m1;
    logic [COUNT_W-1:0] c1;
    logic [MULT_W-1:0]  m2;
  } cfg_t;

  typedef struct packed {
    logic                vld;
    logic [OFFSET_W-1:0] offset;
    logic [LEN_W-1:0]    len;
  } req_t;

  typedef struct packed {
    logic              start;
    logic [GRAN_W-1:0] dividend;
    logic [MULT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [GRAN_W-1:0] quot;
    logic [DREM_W-1:0] rem;
  } div_res_t;

  function automatic logic [MULT_W-1:0] clamp_mult(input logic [MULT_W-1:0] v);
    logic [MULT_W-1:0] r;
    r = v;
    if (v == '0) r = MULT_W'(1);
    else if (v > MULT_MAX) r = MULT_MAX;
    return r;
  endfunction

endpackage

@@ rtl/vcts_front.sv @@
// Front end: takes request words, saturates the length, drops empty ones, queues the rest.
module vcts_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [vcts_pkg::OFFSET_W-1:0] in_start_offset,
  input  logic [vcts_pkg::LEN_W-1:0]    in_transfer_length,
  output vcts_pkg::req_t                req,
  input  logic                          req_pop
);

  vcts_pkg::req_t               entry_r [vcts_pkg::QUEUE_DEPTH];
  logic                         wr_ptr_r, wr_ptr_nxt;
  logic                         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                   count_r, count_nxt;
  logic                         accept;
  logic                         wr_en;
  logic [vcts_pkg::LEN_W-1:0]   len_sat;
  logic                         rd_en;

  assign in_full = (count_r == 2'(vcts_pkg::QUEUE_DEPTH));
  assign accept  = in_push && !in_full;
  assign len_sat = (in_transfer_length > vcts_pkg::MAX_LENGTH) ? vcts_pkg::MAX_LENGTH
                                                                : in_transfer_length;
  assign wr_en   = accept && (len_sat != '0);
  assign rd_en   = req_pop && (count_r != '0);

  always_comb begin
    req        = entry_r[rd_ptr_r];
    req.vld    = (count_r != '0);
    wr_ptr_nxt = wr_en ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r].vld    <= 1'b1;
      entry_r[wr_ptr_r].offset <= in_start_offset;
      entry_r[wr_ptr_r].len    <= len_sat;
    end
  end

endmodule

@@ rtl/vcts_div.sv @@
// Restoring divider, one quotient bit per cycle, for granule number by cluster multiple.
module vcts_div (
  input  logic               clk,
  input  logic               rst_n,
  input  vcts_pkg::div_req_t dreq,
  output vcts_pkg::div_res_t dres
);

  logic                            busy_r;
  logic                            done_r;
  logic [vcts_pkg::DIVCNT_W-1:0]   cnt_r;
  logic [vcts_pkg::GRAN_W-1:0]     quot_r;
  logic [vcts_pkg::DREM_W-1:0]     rem_r;
  logic [vcts_pkg::MULT_W-1:0]     dvs_r;
  logic [vcts_pkg::MULT_W-1:0]     trial;
  logic [vcts_pkg::MULT_W-1:0]     diff;
  logic                            ge;

  assign trial = {rem_r, quot_r[vcts_pkg::GRAN_W-1]};
  assign ge    = (trial >= dvs_r);
  assign diff  = trial - dvs_r;

  assign dres.done = done_r;
  assign dres.quot = quot_r;
  assign dres.rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (dreq.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == vcts_pkg::DIV_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dreq.start) begin
      quot_r <= dreq.dividend;
      rem_r  <= '0;
      dvs_r  <= dreq.divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[vcts_pkg::GRAN_W-2:0], ge};
      rem_r  <= ge ? diff[vcts_pkg::DREM_W-1:0] : trial[vcts_pkg::DREM_W-1:0];
    end
  end

endmodule

@@ rtl/vcts_back.sv @@
// Back end: walks the range table, divides, and issues one segment word at a time.
module vcts_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  vcts_pkg::cfg_t                cfg,
  input  vcts_pkg::req_t                req,
  output logic                          req_pop,
  output vcts_pkg::div_req_t            dreq,
  input  vcts_pkg::div_res_t            dres,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [vcts_pkg::INDEX_W-1:0]  out_cluster_index,
  output logic [vcts_pkg::OFS_W-1:0]    out_offset_in_cluster,
  output logic [vcts_pkg::SIZE_W-1:0]   out_cluster_bytes,
  output logic [vcts_pkg::LEN_W-1:0]    out_segment_bytes,
  output logic                          out_last_segment
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_R0   = 3'd1;
  localparam logic [2:0] ST_R1   = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]                      state_r, state_nxt;
  logic [vcts_pkg::OFFSET_W-1:0]   pos_r, pos_nxt;
  logic [vcts_pkg::LEN_W-1:0]      left_r, left_nxt;
  logic [vcts_pkg::SEGCNT_W-1:0]   seg_r, seg_nxt;
  logic [vcts_pkg::BASE_W-1:0]     base_r, base_nxt;
  logic [vcts_pkg::GRAN_W-1:0]     gran_r, gran_nxt;
  logic [vcts_pkg::MULT_W-1:0]     mult_r, mult_nxt;
  logic                            ovld_r, ovld_nxt;
  logic [vcts_pkg::INDEX_W-1:0]    oidx_r, oidx_nxt;
  logic [vcts_pkg::OFS_W-1:0]      oofs_r, oofs_nxt;
  logic [vcts_pkg::SIZE_W-1:0]     osize_r, osize_nxt;
  logic [vcts_pkg::LEN_W-1:0]      obytes_r, obytes_nxt;
  logic                            olast_r, olast_nxt;

  logic [vcts_pkg::GRAN_W-1:0]     gran0;
  logic [vcts_pkg::PROD_W-1:0]     prod0;
  logic [vcts_pkg::PROD_W-1:0]     prod1;
  logic                            in_r0;
  logic                            in_r1;
  logic [vcts_pkg::OFS_W-1:0]      ofs;
  logic [vcts_pkg::SIZE_W-1:0]     size;
  logic [vcts_pkg::SIZE_W-1:0]     avail;
  logic [vcts_pkg::LEN_W-1:0]      take;
  logic [vcts_pkg::LEN_W-1:0]      left_after;
  logic                            can_load;

  assign gran0 = pos_r[vcts_pkg::OFFSET_W-1:vcts_pkg::GRAN_SHIFT];
  assign prod0 = cfg.m0 * cfg.c0;
  assign prod1 = cfg.m1 * cfg.c1;
  assign in_r0 = (cfg.c0 == '0) || ({4'b0, gran0} < prod0);
  assign in_r1 = (cfg.c1 == '0) || ({4'b0, gran_r} < prod1);

  assign ofs        = {dres.rem, pos_r[vcts_pkg::GRAN_SHIFT-1:0]};
  assign size       = {mult_r, 12'b0};
  assign avail      = size - {1'b0, ofs};
  assign take       = (avail > {1'b0, left_r}) ? left_r : avail[vcts_pkg::LEN_W-1:0];
  assign left_after = left_r - take;
  assign can_load   = !ovld_r || out_pop;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    left_nxt      = left_r;
    seg_nxt       = seg_r;
    base_nxt      = base_r;
    gran_nxt      = gran_r;
    mult_nxt      = mult_r;
    ovld_nxt      = ovld_r && !out_pop;
    oidx_nxt      = oidx_r;
    oofs_nxt      = oofs_r;
    osize_nxt     = osize_r;
    obytes_nxt    = obytes_r;
    olast_nxt     = olast_r;
    req_pop       = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = gran0;
    dreq.divisor  = cfg.m0;
    unique case (state_r)
      ST_IDLE: begin
        if (req.vld) begin
          req_pop   = 1'b1;
          pos_nxt   = req.offset;
          left_nxt  = req.len;
          seg_nxt   = '0;
          state_nxt = ST_R0;
        end
      end
      ST_R0: begin
        if (in_r0) begin
          dreq.start = 1'b1;
          base_nxt   = '0;
          mult_nxt   = cfg.m0;
          state_nxt  = ST_DIV;
        end else begin
          gran_nxt  = gran0 - prod0[vcts_pkg::GRAN_W-1:0];
          base_nxt  = {1'b0, cfg.c0};
          state_nxt = ST_R1;
        end
      end
      ST_R1: begin
        dreq.start = 1'b1;
        state_nxt  = ST_DIV;
        if (in_r1) begin
          dreq.dividend = gran_r;
          dreq.divisor  = cfg.m1;
          mult_nxt      = cfg.m1;
        end else begin
          dreq.dividend = gran_r - prod1[vcts_pkg::GRAN_W-1:0];
          dreq.divisor  = cfg.m2;
          mult_nxt      = cfg.m2;
          base_nxt      = base_r + {1'b0, cfg.c1};
        end
      end
      ST_DIV: begin
        if (dres.done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (can_load) begin
          ovld_nxt   = 1'b1;
          oidx_nxt   = {2'b0, base_r} + dres.quot;
          oofs_nxt   = ofs;
          osize_nxt  = size;
          obytes_nxt = take;
          olast_nxt  = (left_after == '0) || (seg_r == vcts_pkg::SEG_LAST);
          pos_nxt    = pos_r + {13'b0, take};
          seg_nxt    = seg_r + 1'b1;
          left_nxt   = left_after;
          state_nxt  = olast_nxt ? ST_IDLE : ST_R0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
      seg_r   <= '0;
      left_r  <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
      seg_r   <= seg_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r   <= base_nxt;
    gran_r   <= gran_nxt;
    mult_r   <= mult_nxt;
    oidx_r   <= oidx_nxt;
    oofs_r   <= oofs_nxt;
    osize_r  <= osize_nxt;
    obytes_r <= obytes_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_empty             = !ovld_r;
  assign out_cluster_index     = oidx_r;
  assign out_offset_in_cluster = oofs_r;
  assign out_cluster_bytes     = osize_r;
  assign out_segment_bytes     = obytes_r;
  assign out_last_segment      = olast_r;

endmodule

@@ rtl/variable_cluster_transfer_splitter.sv @@
// Top level of the cluster transfer splitter: range registers, front, divider and back.
//
//   channel  direction  handshake           payload
//   in       input      in_push / in_full   start_offset, transfer_length
//   out      output     out_empty / out_pop cluster_index, offset_in_cluster, cluster_bytes,
//                                           segment_bytes, last_segment
//   cfg      input      cfg_we              cfg_index, cfg_wdata
//
// Each segment passes through one or two range-walk states (R0, then R1 when the position lies
// beyond range 0), a wait in DIV on the bit-serial divider (19 quotient bits, until it reports
// done) and EMIT, which loads the output register once that register can take a word.
// A request first leaves the two-word input queue in IDLE, then runs this per segment.
// Reset is synchronous; it clears the queues and the sequencer and loads the range defaults.
// The input queue fills while the back end works; a full output register stalls the back end.
`include "assert_macros.svh"

module variable_cluster_transfer_splitter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [vcts_pkg::OFFSET_W-1:0]   in_start_offset,
  input  logic [vcts_pkg::LEN_W-1:0]      in_transfer_length,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [vcts_pkg::INDEX_W-1:0]    out_cluster_index,
  output logic [vcts_pkg::OFS_W-1:0]      out_offset_in_cluster,
  output logic [vcts_pkg::SIZE_W-1:0]     out_cluster_bytes,
  output logic [vcts_pkg::LEN_W-1:0]      out_segment_bytes,
  output logic                            out_last_segment,
  input  logic                            cfg_we,
  input  logic [vcts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vcts_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  vcts_pkg::cfg_t     cfg_r;
  vcts_pkg::req_t     req;
  logic               req_pop;
  vcts_pkg::div_req_t dreq;
  vcts_pkg::div_res_t dres;
  logic [vcts_pkg::MULT_W-1:0] wmult;
  logic [vcts_pkg::SIZE_W:0]   seg_end;

  assign wmult   = vcts_pkg::clamp_mult(cfg_wdata[vcts_pkg::MULT_W-1:0]);
  assign seg_end = {2'b0, out_offset_in_cluster} + {2'b0, out_segment_bytes};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.m0 <= 7'd1;
      cfg_r.c0 <= 16'd2;
      cfg_r.m1 <= 7'd4;
      cfg_r.c1 <= 16'd4;
      cfg_r.m2 <= 7'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vcts_pkg::REG_RANGE0_MULT:  cfg_r.m0 <= wmult;
        vcts_pkg::REG_RANGE0_COUNT: cfg_r.c0 <= cfg_wdata;
        vcts_pkg::REG_RANGE1_MULT:  cfg_r.m1 <= wmult;
        vcts_pkg::REG_RANGE1_COUNT: cfg_r.c1 <= cfg_wdata;
        vcts_pkg::REG_RANGE2_MULT:  cfg_r.m2 <= wmult;
        default: ;
      endcase
    end
  end

  vcts_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_start_offset    (in_start_offset),
    .in_transfer_length (in_transfer_length),
    .req                (req),
    .req_pop            (req_pop)
  );

  vcts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .dreq  (dreq),
    .dres  (dres)
  );

  vcts_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .req                   (req),
    .req_pop               (req_pop),
    .dreq                  (dreq),
    .dres                  (dres),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_cluster_index     (out_cluster_index),
    .out_offset_in_cluster (out_offset_in_cluster),
    .out_cluster_bytes     (out_cluster_bytes),
    .out_segment_bytes     (out_segment_bytes),
    .out_last_segment      (out_last_segment)
  );

  `VCTS_ASSERT_IMPLIES(a_seg_nonzero, !out_empty, out_segment_bytes != '0)
  `VCTS_ASSERT_IMPLIES(a_seg_in_cluster, !out_empty, seg_end <= {1'b0, out_cluster_bytes})
  `VCTS_ASSERT_ALWAYS(a_cfg_mult_legal, (cfg_r.m0 != '0) && (cfg_r.m1 != '0) && (cfg_r.m2 != '0))

endmodule
